### src/bem_pkg.sv
// shared types and constants for the byte entropy meter
// no dependencies; imported by every module of the block
`default_nettype none
package bem_pkg;

   localparam int COUNT_BITS = 27;
   localparam int FRAC_BITS  = 16;
   localparam int BIN_COUNT  = 256;
   localparam int BIN_BITS   = 8;
   localparam int MANT_W     = 32;
   localparam int IP_BITS    = 5;
   localparam int LOG_W      = IP_BITS + FRAC_BITS;
   localparam int SUM_W      = COUNT_BITS + LOG_W;
   localparam int ENT_W      = 20;
   localparam int ITER_BITS  = $clog2(FRAC_BITS);
   localparam int DIV_BITS   = $clog2(SUM_W);
   localparam logic [COUNT_BITS-1:0] COUNT_BOUND = COUNT_BITS'(1) << (COUNT_BITS - 1);
   localparam logic [SUM_W-1:0] ENT_MAX = SUM_W'(8) << FRAC_BITS;

   typedef struct packed {
      logic [BIN_BITS-1:0] byte_value;
      logic                has_byte;
      logic                is_last;
   } bem_req_type;

   typedef struct packed {
      logic [ENT_W-1:0]      entropy_q16;
      logic [COUNT_BITS-1:0] byte_count;
      logic                  overflow;
   } bem_rsp_type;

endpackage
`default_nettype wire

### src/bem_log2.sv
// fixed-point log2 unit: shift normalization, then one squaring per cycle
// depends on bem_pkg
`default_nettype none
module bem_log2 (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [bem_pkg::COUNT_BITS-1:0] x,
   output logic                               done,
   output logic [bem_pkg::LOG_W-1:0]          result
);
   import bem_pkg::*;

   typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_SQ} lg_state_type;

   lg_state_type            state_ff;
   logic [MANT_W-1:0]       m_ff;
   logic [IP_BITS-1:0]      ip_ff;
   logic [FRAC_BITS-1:0]    frac_ff;
   logic [ITER_BITS-1:0]    iter_ff;
   logic                    done_ff;
   logic [2*MANT_W-1:0]     sq;

   // square of the mantissa, renormalized by its top bit in LG_SQ
   assign sq = {MANT_W'(0), m_ff} * {MANT_W'(0), m_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            LG_IDLE: begin
               if (start) begin
                  m_ff     <= MANT_W'(x);
                  ip_ff    <= IP_BITS'(MANT_W - 1);
                  frac_ff  <= '0;
                  state_ff <= LG_NORM;
               end
            end
            LG_NORM: begin
               // shift until the leading one sits at the top
               if (m_ff[MANT_W-1]) begin
                  iter_ff  <= '0;
                  state_ff <= LG_SQ;
               end else begin
                  m_ff  <= m_ff << 1;
                  ip_ff <= ip_ff - IP_BITS'(1);
               end
            end
            LG_SQ: begin
               m_ff    <= sq[2*MANT_W-1] ? sq[2*MANT_W-1:MANT_W] : sq[2*MANT_W-2:MANT_W-1];
               frac_ff <= {frac_ff[FRAC_BITS-2:0], sq[2*MANT_W-1]};
               iter_ff <= iter_ff + ITER_BITS'(1);
               if (iter_ff == ITER_BITS'(FRAC_BITS - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= LG_IDLE;
               end
            end
            default: state_ff <= LG_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = {ip_ff, frac_ff};

endmodule
`default_nettype wire

### src/byte_entropy_meter.sv
// byte entropy meter top level: histogram memory, end-of-block sweep, divider
// depends on bem_pkg and bem_log2
`default_nettype none
// Bytes are taken one per cycle while busy is low; each counted byte updates a
// 256-entry histogram memory by a read-modify-write with one-entry forwarding.
// An item with is_last raises busy and starts the end-of-block pass: a drain
// state to retire the last update, a read and a wait state per empty bin, and
// for each nonzero bin a log2 on the shared log unit (up to 32 normalize steps
// plus 16 squarings, one per cycle) and a multiply-accumulate; then a log2 of
// the byte count and a 48-step bit-serial divide. An empty block skips the
// sweep and answers from the drain state. The result on rsp_data is marked by
// rsp_strobe, high for one cycle; the receiver cannot stall it, and busy falls
// in that cycle. Histogram clearing is instant through per-entry valid bits.
module byte_entropy_meter (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire bem_pkg::bem_req_type req_data,
   output logic                      busy,
   output logic                      rsp_strobe,
   output bem_pkg::bem_rsp_type      rsp_data
);
   import bem_pkg::*;

   typedef enum logic [2:0] {
      ST_RUN, ST_DRAIN, ST_RD, ST_WAIT, ST_LOGF, ST_ACC, ST_LOGN, ST_DIV
   } state_type;

   // histogram memory and its read port
   logic [COUNT_BITS-1:0] hist_mem [BIN_COUNT];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  rd_valid_ff;
   logic [BIN_COUNT-1:0]  valid_ff;
   logic [BIN_BITS-1:0]   rd_addr;

   // update stage and forwarding register
   logic                  p1_valid_ff, p1_valid_in;
   logic [BIN_BITS-1:0]   p1_addr_ff;
   logic                  fw_valid_ff;
   logic [BIN_BITS-1:0]   fw_addr_ff;
   logic [COUNT_BITS-1:0] fw_cnt_ff;
   logic [COUNT_BITS-1:0] cnt_old, cnt_new;

   // control and datapath registers
   state_type             state_ff, state_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic                  ovf_ff, ovf_in;
   logic [BIN_BITS-1:0]   bin_ff, bin_in;
   logic [COUNT_BITS-1:0] f_ff, f_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [LOG_W-1:0]      logn_ff, logn_in;
   logic [COUNT_BITS:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [DIV_BITS-1:0]   dcnt_ff, dcnt_in;
   logic                  strobe_ff, strobe_in;
   bem_rsp_type           rsp_ff, rsp_in;
   logic                  clear;

   // log unit
   logic                  log_start;
   logic [COUNT_BITS-1:0] log_x;
   logic                  log_done;
   logic [LOG_W-1:0]      log_res;

   // divide step
   logic [COUNT_BITS:0]   rsh;
   logic [SUM_W-1:0]      logn_ext;

   bem_log2 u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   assign rd_addr = (state_ff == ST_RUN) ? req_data.byte_value : bin_ff;

   // bin count with forwarding from the previous write
   assign cnt_old = (fw_valid_ff && fw_addr_ff == p1_addr_ff) ? fw_cnt_ff :
                    (rd_valid_ff ? rd_data_ff : '0);
   assign cnt_new = cnt_old + COUNT_BITS'(1);

   assign rsh      = {rem_ff[COUNT_BITS-1:0], quo_ff[SUM_W-1]};
   assign logn_ext = SUM_W'(logn_ff);

   // next-state logic
   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      ovf_in      = ovf_ff;
      bin_in      = bin_ff;
      f_in        = f_ff;
      sum_in      = sum_ff;
      logn_in     = logn_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dcnt_in     = dcnt_ff;
      rsp_in      = rsp_ff;
      strobe_in   = 1'b0;
      p1_valid_in = 1'b0;
      log_start   = 1'b0;
      log_x       = f_ff;
      clear       = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (start) begin
               if (req_data.has_byte) begin
                  if (total_ff >= COUNT_BOUND) begin
                     ovf_in = 1'b1;
                  end else begin
                     total_in    = total_ff + COUNT_BITS'(1);
                     p1_valid_in = 1'b1;
                  end
               end
               if (req_data.is_last) state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            bin_in = '0;
            sum_in = '0;
            if (total_ff == '0) begin
               rsp_in    = '{entropy_q16: '0, byte_count: total_ff, overflow: ovf_ff};
               strobe_in = 1'b1;
               clear     = 1'b1;
               state_in  = ST_RUN;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            f_in  = rd_valid_ff ? rd_data_ff : '0;
            log_x = f_in;
            if (f_in != '0) begin
               log_start = 1'b1;
               state_in  = ST_LOGF;
            end else if (bin_ff == BIN_BITS'(BIN_COUNT - 1)) begin
               log_x     = total_ff;
               log_start = 1'b1;
               state_in  = ST_LOGN;
            end else begin
               bin_in   = bin_ff + BIN_BITS'(1);
               state_in = ST_RD;
            end
         end
         ST_LOGF: begin
            if (log_done) begin
               // accumulate f * log2(f)
               sum_in   = sum_ff + SUM_W'(f_ff * log_res);
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (bin_ff == BIN_BITS'(BIN_COUNT - 1)) begin
               log_x     = total_ff;
               log_start = 1'b1;
               state_in  = ST_LOGN;
            end else begin
               bin_in   = bin_ff + BIN_BITS'(1);
               state_in = ST_RD;
            end
         end
         ST_LOGN: begin
            if (log_done) begin
               logn_in  = log_res;
               rem_in   = '0;
               quo_in   = sum_ff;
               dcnt_in  = DIV_BITS'(SUM_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (rsh >= {1'b0, total_ff}) begin
               rem_in = rsh - {1'b0, total_ff};
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rsh;
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - DIV_BITS'(1);
            if (dcnt_ff == '0) begin
               // result registered at this edge by the path below
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   // result registered when the divide completes
   logic div_last;
   assign div_last = (state_ff == ST_DIV) && (dcnt_ff == '0);

   logic [SUM_W-1:0] quo_fin;
   logic [SUM_W-1:0] diff_fin, h_fin;
   assign quo_fin  = quo_in;
   assign diff_fin = logn_ext - quo_fin;
   always_comb begin
      h_fin = (logn_ext > quo_fin) ? diff_fin : '0;
      if (h_fin > ENT_MAX) h_fin = ENT_MAX;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_RUN;
         total_ff    <= '0;
         ovf_ff      <= 1'b0;
         valid_ff    <= '0;
         p1_valid_ff <= 1'b0;
         fw_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         p1_valid_ff <= p1_valid_in;
         strobe_ff   <= strobe_in || div_last;
         if (clear || div_last) begin
            total_ff    <= '0;
            ovf_ff      <= 1'b0;
            valid_ff    <= '0;
            fw_valid_ff <= 1'b0;
         end else begin
            total_ff    <= total_in;
            ovf_ff      <= ovf_in;
            fw_valid_ff <= p1_valid_ff;
            if (p1_valid_ff) valid_ff[p1_addr_ff] <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      f_ff       <= f_in;
      sum_ff     <= sum_in;
      logn_ff    <= logn_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      dcnt_ff    <= dcnt_in;
      p1_addr_ff <= req_data.byte_value;
      fw_addr_ff <= p1_addr_ff;
      fw_cnt_ff  <= cnt_new;
      if (div_last) begin
         rsp_ff <= '{entropy_q16: h_fin[ENT_W-1:0], byte_count: total_ff, overflow: ovf_ff};
      end else begin
         rsp_ff <= rsp_in;
      end
   end

   // histogram memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (p1_valid_ff) hist_mem[p1_addr_ff] <= cnt_new;
      rd_data_ff  <= hist_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign busy       = (state_ff != ST_RUN);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

### src/bem_checker.sv
// port-level checks for the byte entropy meter, bound to the top level
// depends on bem_pkg
`default_nettype none
module bem_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire bem_pkg::bem_req_type req_data,
   input wire logic                 busy,
   input wire logic                 rsp_strobe,
   input wire bem_pkg::bem_rsp_type rsp_data
);
   import bem_pkg::*;

   // a closing transaction makes the block busy
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.is_last |=> busy)
      else $error("closing transaction did not raise busy");

   // no back-to-back results
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in a row");

   // entropy never above 8 bits per byte
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (ENT_W'(rsp_data.entropy_q16) <= ENT_W'(ENT_MAX)))
      else $error("entropy above 8.0");

   // overflow only once the count reached the bound
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.overflow |-> rsp_data.byte_count == COUNT_BOUND)
      else $error("overflow below the count bound");

endmodule

bind byte_entropy_meter bem_checker u_bem_checker (.*);
`default_nettype wire
